### rtl/pls_pkg.sv
`default_nettype none
package pls_pkg;

	localparam int TIME_W = 32;
	localparam int TEMP_W = 16;
	localparam int SEG_W = 5;
	localparam int CMD_W = 2;
	localparam int IDX_W = 4;
	localparam int MAX_POINTS_DEF = 16;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [TEMP_W-1:0] temp_t;

	typedef struct packed {
		time_t bp_time;
		temp_t bp_temp;
	} point_t;

endpackage
`default_nettype wire

### rtl/pls_mem.sv
`default_nettype none
module pls_mem #(
	parameter int DEPTH = pls_pkg::MAX_POINTS_DEF,
	parameter int ADDR_W = $clog2(pls_pkg::MAX_POINTS_DEF)
) (
	input  wire                      clk,
	input  wire                      wr_en,
	input  wire  [ADDR_W-1:0]        wr_addr,
	input  wire  pls_pkg::point_t    wr_data,
	input  wire  [ADDR_W-1:0]        rd_addr,
	output pls_pkg::point_t          rd_data
);
	import pls_pkg::*;

	point_t mem [DEPTH];
	point_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### rtl/pls_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits TEMP_W bits, so the upper dividend bits start as remainder.
module pls_div (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  [pls_pkg::TIME_W+pls_pkg::TEMP_W-1:0] dividend,
	input  wire  [pls_pkg::TIME_W-1:0]       divisor,
	output logic                             done,
	output pls_pkg::temp_t                   quotient
);
	import pls_pkg::*;

	localparam int CNT_W = $clog2(TEMP_W) + 1;

	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] dvs_q;
	logic [TEMP_W-1:0] lo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [TIME_W:0]   trial;
	logic              qbit;

	always_comb begin
		trial = {rem_q, lo_q[TEMP_W-1]} - {1'b0, dvs_q};
		qbit = ~trial[TIME_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TEMP_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[TIME_W+TEMP_W-1:TEMP_W];
			lo_q <= dividend[TEMP_W-1:0];
			dvs_q <= divisor;
		end else if (run_q) begin
			if (qbit) begin
				rem_q <= trial[TIME_W-1:0];
			end else begin
				rem_q <= {rem_q[TIME_W-2:0], lo_q[TEMP_W-1]};
			end
			lo_q <= {lo_q[TEMP_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quotient = lo_q;

endmodule
`default_nettype wire

### rtl/piecewise_linear_setpoint.sv
// A tick request searches from slot 0 and ends at slot k, below the points in use.
// Without interpolation the strobe is set as the search ends; when it interpolates,
// the MUL state and a serial divide follow first. The search reads one slot per
// cycle from the breakpoint memory. Write and restart requests never make it busy;
// a tick frees the input in its strobe cycle.
// Reset clears the elapsed time and sets points in use to 1; breakpoints stay.
`default_nettype none
module piecewise_linear_setpoint #(
	parameter int MAX_POINTS = pls_pkg::MAX_POINTS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [pls_pkg::CMD_W-1:0]    cmd,
	input  wire  [pls_pkg::IDX_W-1:0]    point_index,
	input  wire  [pls_pkg::TIME_W-1:0]   point_time,
	input  wire  [pls_pkg::TEMP_W-1:0]   point_temp,
	input  wire                          cfg_we,
	input  wire  [pls_pkg::SEG_W-1:0]    cfg_wdata,
	output logic                         strobe,
	output logic [pls_pkg::TEMP_W-1:0]   setpoint,
	output logic [pls_pkg::SEG_W-1:0]    segment,
	output logic                         finished
);
	import pls_pkg::*;

	localparam int ADDR_W = $clog2(MAX_POINTS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_MUL    = 4'b0100,
		ST_DIV    = 4'b1000
	} state_t;

	state_t            state_q;
	logic [SEG_W-1:0]  num_points_q;
	logic [SEG_W-1:0]  n_eff;
	logic [SEG_W-1:0]  n_q;
	time_t             elapsed_q;
	logic [SEG_W-1:0]  cmp_q;
	logic [SEG_W-1:0]  cmp_next;
	point_t            prev_q;
	point_t            cur_q;
	logic              up_q;

	logic              accept;
	logic              wr_en;
	logic [ADDR_W+IDX_W-1:0] wr_idx_ext;
	logic [ADDR_W+SEG_W-1:0] rd_idx_ext;
	logic [ADDR_W-1:0] rd_addr;
	point_t            wr_data;
	point_t            rd_data;
	logic              hit;

	time_t             into;
	time_t             span;
	temp_t             diff;
	logic [TIME_W+TEMP_W-1:0] prod;
	logic              div_start;
	logic              div_done;
	temp_t             quot;

	logic              strobe_q;
	temp_t             setpoint_q;
	logic [SEG_W-1:0]  segment_q;
	logic              finished_q;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		if (num_points_q == '0) begin
			n_eff = SEG_W'(1);
		end else if (32'(num_points_q) > MAX_POINTS) begin
			n_eff = SEG_W'(MAX_POINTS);
		end else begin
			n_eff = num_points_q;
		end
	end

	// breakpoint memory
	assign wr_idx_ext = {{ADDR_W{1'b0}}, point_index};
	assign wr_en = accept && (cmd == CMD_WRITE) && (32'(point_index) < MAX_POINTS);
	assign wr_data = '{bp_time: point_time, bp_temp: point_temp};
	assign cmp_next = cmp_q + 1'b1;
	assign rd_idx_ext = {{ADDR_W{1'b0}}, cmp_next};
	assign rd_addr = (state_q == ST_SEARCH) ? rd_idx_ext[ADDR_W-1:0] : '0;

	pls_mem #(
		.DEPTH  (MAX_POINTS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_ext[ADDR_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign hit = rd_data.bp_time > elapsed_q;

	// interval math: t0 <= elapsed < t1, so the quotient never exceeds diff
	always_comb begin
		into = elapsed_q - prev_q.bp_time;
		span = cur_q.bp_time - prev_q.bp_time;
		diff = up_q ? (cur_q.bp_temp - prev_q.bp_temp) : (prev_q.bp_temp - cur_q.bp_temp);
		prod = (TIME_W+TEMP_W)'(into) * (TIME_W+TEMP_W)'(diff);
	end

	assign div_start = (state_q == ST_MUL);

	pls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (span),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_points_q <= SEG_W'(1);
			elapsed_q <= '0;
			strobe_q <= 1'b0;
			cmp_q <= '0;
			n_q <= SEG_W'(1);
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				num_points_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd == CMD_RESTART) begin
						elapsed_q <= '0;
					end else if (accept && cmd == CMD_TICK) begin
						if (elapsed_q != '1) begin
							elapsed_q <= elapsed_q + 1'b1;
						end
						cmp_q <= '0;
						n_q <= n_eff;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						if (cmp_q == '0) begin
							strobe_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_MUL;
						end
					end else if (cmp_next == n_q) begin
						strobe_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cmp_q <= cmp_next;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						strobe_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SEARCH: begin
				if (hit) begin
					segment_q <= cmp_q;
					finished_q <= 1'b0;
					cur_q <= rd_data;
					up_q <= rd_data.bp_temp >= prev_q.bp_temp;
					// before the first breakpoint: hold its temperature
					setpoint_q <= rd_data.bp_temp;
				end else begin
					prev_q <= rd_data;
					if (cmp_next == n_q) begin
						segment_q <= n_q;
						finished_q <= 1'b1;
						setpoint_q <= rd_data.bp_temp;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					setpoint_q <= up_q ? (prev_q.bp_temp + quot) : (prev_q.bp_temp - quot);
				end
			end
			default: begin
			end
		endcase
	end

	assign strobe = strobe_q;
	assign setpoint = setpoint_q;
	assign segment = segment_q;
	assign finished = finished_q;

endmodule
`default_nettype wire

### rtl/pls_chk.sv
`default_nettype none
module pls_chk (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       start,
	input wire                       busy,
	input wire [pls_pkg::CMD_W-1:0]  cmd,
	input wire                       strobe,
	input wire [pls_pkg::SEG_W-1:0]  segment,
	input wire                       finished
);
	import pls_pkg::*;

	// a result only follows a tick in progress
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result strobe without a tick in progress");

	a_tick_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_TICK) |=> busy)
		else $error("tick request did not start work");

	a_other_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd != CMD_TICK) |=> (!busy && !strobe))
		else $error("non-tick request caused work or a result");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("back-to-back result strobes");

	a_finished_segment: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && finished) |-> (segment != '0))
		else $error("finished with segment zero");

endmodule

bind piecewise_linear_setpoint pls_chk u_pls_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.cmd      (cmd),
	.strobe   (strobe),
	.segment  (segment),
	.finished (finished)
);
`default_nettype wire
